>>> sv/assert_macros.svh
// Assertion helpers for clk / arst_n based checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> sv/mag_pkg.sv
package mag_pkg;

	localparam int PAGE_SHIFT = 12;
	localparam longint CAP_CEILING = 262144;

	localparam int KIND_W     = 3;
	localparam int AMT_W      = 36;
	localparam int BYTES_IN_W = 48;
	localparam int REFUSAL_W  = 3;
	localparam int COUNT_W    = 41;
	localparam int AGE_W      = 16;
	localparam int PLIM_W     = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam int SHIFTED_W = AMT_W + PAGE_SHIFT;
	localparam int CMP_W     = (SHIFTED_W > BYTES_IN_W) ? SHIFTED_W : BYTES_IN_W;
	localparam int BRK_W     = BYTES_IN_W + 8;

	localparam logic [BRK_W-1:0] ENGAGE_MUL  = BRK_W'(10);
	localparam logic [BRK_W-1:0] RELEASE_MUL = BRK_W'(100);
	localparam logic [BRK_W-1:0] RELEASE_PCT = BRK_W'(15);

	localparam logic [AGE_W-1:0] STALE_RESET = AGE_W'(2000);

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS    = 3'd0,
		KIND_TICK      = 3'd1,
		KIND_RESERVE   = 3'd2,
		KIND_UNRESERVE = 3'd3,
		KIND_CHARGE    = 3'd4
	} kind_t;

	typedef enum logic [REFUSAL_W-1:0] {
		REF_NONE     = 3'd0,
		REF_OVERSIZE = 3'd1,
		REF_STALE    = 3'd2,
		REF_BRAKE    = 3'd3,
		REF_LEDGER   = 3'd4
	} refusal_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_LIMIT   = 2'd0,
		CFG_STALE_WINDOW = 2'd1
	} cfg_idx_t;

	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W:0] v);
		logic [COUNT_W-1:0] r;
		if (v[COUNT_W] != v[COUNT_W-1])
			r = v[COUNT_W] ? {1'b1, {(COUNT_W-1){1'b0}}} : {1'b0, {(COUNT_W-1){1'b1}}};
		else
			r = v[COUNT_W-1:0];
		return r;
	endfunction

endpackage

>>> sv/memory_admission_governor_top.sv
// Memory admission governor: takes one request per clock unless item_stall is high
// (status update, millisecond tick, reserve, unreserve or charge) and returns exactly
// one result per request, through the input register, where all decisions and account
// updates happen, and then the result register. A stalled result holds the input
// register, which then stalls the request side. While a finished result waits, one new
// request can still be taken if the input register is empty. Configuration writes
// (page_limit at index 0, stale_window_ms at index 1) are always ready and take effect
// on the next request; write them only while no request is in flight.
`include "assert_macros.svh"

module memory_admission_governor_top (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [mag_pkg::KIND_W-1:0]        kind,
	input  logic [mag_pkg::AMT_W-1:0]         page_amount,
	input  logic [mag_pkg::BYTES_IN_W-1:0]    mem_limit,
	input  logic [mag_pkg::BYTES_IN_W-1:0]    headroom,
	input  logic                              crit_pressure,

	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              granted,
	output logic [mag_pkg::REFUSAL_W-1:0]     refusal,
	output logic                              brake_on,
	output logic                              brake_changed,
	output logic                              footprint_on,
	output logic                              feed_stale,
	output logic signed [mag_pkg::COUNT_W-1:0] pages_in_use,
	output logic [mag_pkg::AMT_W-1:0]         credit_left,
	output logic                              negative_seen,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mag_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mag_pkg::*;

	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [AMT_W-1:0]      pages_s1;
	logic [BYTES_IN_W-1:0] limit_s1;
	logic [BYTES_IN_W-1:0] avail_s1;
	logic                  crit_s1;

	logic                  brake_q;
	logic                  feed_seen_q;
	logic [BYTES_IN_W-1:0] feed_limit_q;
	logic [AGE_W-1:0]      feed_age_q;
	logic [COUNT_W-1:0]    count_q;
	logic [AMT_W-1:0]      credit_q;
	logic                  clamp_q;
	logic [PLIM_W-1:0]     page_limit_q;
	logic [AGE_W-1:0]      stale_window_q;

	logic                  nxt_brake;
	logic                  nxt_seen;
	logic [BYTES_IN_W-1:0] nxt_limit;
	logic [AGE_W-1:0]      nxt_age;
	logic [COUNT_W-1:0]    nxt_count;
	logic [AMT_W-1:0]      nxt_credit;
	logic                  nxt_clamp;
	logic                  granted_c;
	logic [REFUSAL_W-1:0]  refusal_c;
	logic                  changed_c;

	logic                  adv;
	logic                  step;
	logic                  item_acc;

	logic [BRK_W-1:0]      lim_w;
	logic [BRK_W-1:0]      avail_w;
	logic                  engage;
	logic                  hold_brake;
	logic [CMP_W-1:0]      bytes_ext;
	logic [CMP_W-1:0]      feed_lim_ext;
	logic                  stale_now;
	logic [COUNT_W:0]      count_ext;
	logic [COUNT_W:0]      pages_ext;
	logic [COUNT_W:0]      add_sum;
	logic [COUNT_W:0]      sub_sum;
	logic [COUNT_W-1:0]    ledger_base;
	logic [COUNT_W:0]      ledger_sum;
	logic [COUNT_W:0]      cap_ext;
	logic [AMT_W-1:0]      uncovered;
	logic [COUNT_W:0]      charge_sum;
	logic [PLIM_W-1:0]     cfg_limit;

	assign adv        = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign item_acc   = item_valid && !item_stall;
	assign step       = valid_s1 && adv;
	assign cfg_ready  = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			kind_s1  <= kind;
			pages_s1 <= page_amount;
			limit_s1 <= mem_limit;
			avail_s1 <= headroom;
			crit_s1  <= crit_pressure;
		end
	end

	assign lim_w      = BRK_W'(limit_s1);
	assign avail_w    = BRK_W'(avail_s1);
	assign engage     = crit_s1 || ((avail_w * ENGAGE_MUL) < lim_w);
	assign hold_brake = brake_q && ((avail_w * RELEASE_MUL) < (lim_w * RELEASE_PCT));

	assign bytes_ext    = CMP_W'({pages_s1, {PAGE_SHIFT{1'b0}}});
	assign feed_lim_ext = CMP_W'(feed_limit_q);
	assign stale_now    = feed_age_q > stale_window_q;

	assign count_ext   = {count_q[COUNT_W-1], count_q};
	assign pages_ext   = {{(COUNT_W+1-AMT_W){1'b0}}, pages_s1};
	assign add_sum     = count_ext + pages_ext;
	assign sub_sum     = count_ext - pages_ext;
	assign ledger_base = count_q[COUNT_W-1] ? '0 : count_q;
	assign ledger_sum  = {1'b0, ledger_base} + pages_ext;
	assign cap_ext     = {{(COUNT_W+1-PLIM_W){1'b0}}, page_limit_q};
	assign uncovered   = pages_s1 - credit_q;
	assign charge_sum  = count_ext + {{(COUNT_W+1-AMT_W){1'b0}}, uncovered};

	always_comb begin
		nxt_brake  = brake_q;
		nxt_seen   = feed_seen_q;
		nxt_limit  = feed_limit_q;
		nxt_age    = feed_age_q;
		nxt_count  = count_q;
		nxt_credit = credit_q;
		nxt_clamp  = clamp_q;
		granted_c  = 1'b0;
		refusal_c  = REF_NONE;
		changed_c  = 1'b0;
		case (kind_s1)
			KIND_STATUS: begin
				if (limit_s1 != '0) begin
					nxt_brake = engage || hold_brake;
					changed_c = nxt_brake != brake_q;
					nxt_limit = limit_s1;
					nxt_age   = '0;
					nxt_seen  = 1'b1;
				end
			end
			KIND_TICK: begin
				if (feed_age_q != '1)
					nxt_age = feed_age_q + 1'b1;
			end
			KIND_RESERVE: begin
				if (feed_seen_q) begin
					if (feed_limit_q != '0 && bytes_ext > feed_lim_ext) begin
						refusal_c = REF_OVERSIZE;
					end else if (stale_now) begin
						refusal_c = REF_STALE;
					end else if (brake_q) begin
						refusal_c = REF_BRAKE;
					end else begin
						nxt_count  = sat_count(add_sum);
						nxt_credit = pages_s1;
						granted_c  = 1'b1;
					end
				end else begin
					// clamp a negative count before the cap check, even if refused
					nxt_count = ledger_base;
					if (count_q[COUNT_W-1])
						nxt_clamp = 1'b1;
					if (ledger_sum > cap_ext) begin
						refusal_c = REF_LEDGER;
					end else begin
						nxt_count  = sat_count(ledger_sum);
						nxt_credit = pages_s1;
						granted_c  = 1'b1;
					end
				end
			end
			KIND_UNRESERVE: begin
				nxt_count = sat_count(sub_sum);
			end
			KIND_CHARGE: begin
				nxt_credit = '0;
				if (credit_q < pages_s1)
					nxt_count = sat_count(charge_sum);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brake_q      <= 1'b0;
			feed_seen_q  <= 1'b0;
			feed_limit_q <= '0;
			feed_age_q   <= '0;
			count_q      <= '0;
			credit_q     <= '0;
			clamp_q      <= 1'b0;
		end else if (step) begin
			brake_q      <= nxt_brake;
			feed_seen_q  <= nxt_seen;
			feed_limit_q <= nxt_limit;
			feed_age_q   <= nxt_age;
			count_q      <= nxt_count;
			credit_q     <= nxt_credit;
			clamp_q      <= nxt_clamp;
		end
	end

	// configuration registers
	assign cfg_limit = (64'(cfg_data[PLIM_W-1:0]) > 64'(CAP_CEILING)) ?
		PLIM_W'(CAP_CEILING) : cfg_data[PLIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q   <= PLIM_W'(CAP_CEILING);
			stale_window_q <= STALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAGE_LIMIT: begin
					if (cfg_data[PLIM_W-1:0] != '0)
						page_limit_q <= cfg_limit;
				end
				CFG_STALE_WINDOW: begin
					stale_window_q <= cfg_data[AGE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			granted       <= granted_c;
			refusal       <= refusal_c;
			brake_on      <= nxt_brake;
			brake_changed <= changed_c;
			footprint_on  <= nxt_seen;
			feed_stale    <= nxt_seen && (nxt_age > stale_window_q);
			pages_in_use  <= nxt_count;
			credit_left   <= nxt_credit;
			negative_seen <= nxt_clamp;
		end
	end

	`ASSERT_IMPL(a_grant_no_refusal, result_valid && granted, refusal == REF_NONE)
	`ASSERT_IMPL(a_stale_needs_feed, result_valid && feed_stale, footprint_on)
	`ASSERT_NEXT(a_footprint_sticky, result_valid && footprint_on, !result_valid || footprint_on)

endmodule

>>> tb/memory_admission_governor_top_tb.sv
`timescale 1ns / 100ps

module memory_admission_governor_top_tb;
	import mag_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam longint COUNT_HI = (64'sd1 <<< (COUNT_W - 1)) - 1;
	localparam longint COUNT_LO = -(64'sd1 <<< (COUNT_W - 1));
	localparam logic [AMT_W-1:0] AMT_MAX = '1;
	localparam logic [BYTES_IN_W-1:0] BYTES_MAX = '1;

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [AMT_W-1:0]      pages;
		logic [BYTES_IN_W-1:0] lim;
		logic [BYTES_IN_W-1:0] avail;
		logic                  crit;
	} req_t;

	typedef struct {
		logic                      granted;
		logic [REFUSAL_W-1:0]      refusal;
		logic                      brake_on;
		logic                      brake_changed;
		logic                      footprint_on;
		logic                      feed_stale;
		logic signed [COUNT_W-1:0] pages_in_use;
		logic [AMT_W-1:0]          credit_left;
		logic                      negative_seen;
	} outcome_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HOLD} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic [KIND_W-1:0]          kind = '0;
	logic [AMT_W-1:0]           page_amount = '0;
	logic [BYTES_IN_W-1:0]      mem_limit = '0;
	logic [BYTES_IN_W-1:0]      headroom = '0;
	logic                       crit_pressure = 1'b0;

	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic                       granted;
	logic [REFUSAL_W-1:0]       refusal;
	logic                       brake_on;
	logic                       brake_changed;
	logic                       footprint_on;
	logic                       feed_stale;
	logic signed [COUNT_W-1:0]  pages_in_use;
	logic [AMT_W-1:0]           credit_left;
	logic                       negative_seen;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	memory_admission_governor_top dut (.*);

	// governor state as predicted
	logic                  brake_st;
	logic                  footprint_st;
	logic                  clamp_st;
	logic [BYTES_IN_W-1:0] feed_lim;
	logic [AGE_W-1:0]      feed_age_st;
	longint                page_acct;
	logic [AMT_W-1:0]      parked;
	logic [PLIM_W-1:0]     cap_pages;
	logic [AGE_W-1:0]      stale_window;

	req_t        request_backlog[$];
	outcome_t    awaited_results[$];
	int          errors = 0;
	int          idle_cycles = 0;
	logic        req_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          gap_max = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          hold_cnt = 0;
	int          pat_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip_count(input longint v);
		if (v > COUNT_HI)
			return COUNT_HI;
		if (v < COUNT_LO)
			return COUNT_LO;
		return v;
	endfunction

	function automatic outcome_t govern(input logic [KIND_W-1:0] k, input logic [AMT_W-1:0] pg,
			input logic [BYTES_IN_W-1:0] lim, input logic [BYTES_IN_W-1:0] av, input logic crit);
		outcome_t o;
		logic next_brake;
		longint unsigned l, a, bytes;
		longint amt, cap;
		o.granted = 1'b0;
		o.refusal = REF_NONE;
		o.brake_changed = 1'b0;
		l = lim;
		a = av;
		amt = pg;
		cap = cap_pages;
		bytes = amt << PAGE_SHIFT;
		case (k)
			KIND_STATUS: begin
				if (lim != 0) begin
					next_brake = crit || (a * 10 < l) || (brake_st && a * 100 < l * 15);
					o.brake_changed = next_brake != brake_st;
					brake_st = next_brake;
					feed_lim = lim;
					feed_age_st = '0;
					footprint_st = 1'b1;
				end
			end
			KIND_TICK: begin
				if (feed_age_st != '1)
					feed_age_st++;
			end
			KIND_RESERVE: begin
				if (footprint_st) begin
					if (feed_lim != 0 && bytes > feed_lim)
						o.refusal = REF_OVERSIZE;
					else if (feed_age_st > stale_window)
						o.refusal = REF_STALE;
					else if (brake_st)
						o.refusal = REF_BRAKE;
				end else begin
					if (page_acct < 0) begin
						page_acct = 0;
						clamp_st = 1'b1;
					end
					if (page_acct + amt > cap)
						o.refusal = REF_LEDGER;
				end
				if (o.refusal == REF_NONE) begin
					page_acct = clip_count(page_acct + amt);
					parked = pg;
					o.granted = 1'b1;
				end
			end
			KIND_UNRESERVE: page_acct = clip_count(page_acct - amt);
			KIND_CHARGE: begin
				if (parked < pg)
					page_acct = clip_count(page_acct + (amt - longint'(parked)));
				parked = '0;
			end
			default: ;
		endcase
		o.brake_on = brake_st;
		o.footprint_on = footprint_st;
		o.feed_stale = footprint_st && feed_age_st > stale_window;
		o.pages_in_use = page_acct[COUNT_W-1:0];
		o.credit_left = parked;
		o.negative_seen = clamp_st;
		return o;
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function automatic logic [BYTES_IN_W-1:0] rand48();
		return BYTES_IN_W'({$urandom, $urandom});
	endfunction

	function automatic logic [AMT_W-1:0] rand_pages();
		case ($urandom_range(0, 9))
			0: return AMT_MAX;
			1, 2: return AMT_W'({$urandom, $urandom});
			3: return AMT_W'($urandom_range(0, 400000));
			default: return AMT_W'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic void queue_req(input logic [KIND_W-1:0] k, input logic [AMT_W-1:0] pg,
			input logic [BYTES_IN_W-1:0] lim, input logic [BYTES_IN_W-1:0] av, input logic crit);
		req_t r;
		r.kind = k;
		r.pages = pg;
		r.lim = lim;
		r.avail = av;
		r.crit = crit;
		request_backlog.push_back(r);
	endfunction

	// calm: fresh feed with enough headroom to keep the brake released
	function automatic void queue_status(input bit calm);
		longint unsigned l, a;
		logic c;
		c = 1'b0;
		if (calm) begin
			l = rand48() | 1;
			a = l - (l >> $urandom_range(1, 8));
		end else begin
			c = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0: begin
					l = 0;
					a = rand48();
				end
				1: begin
					l = BYTES_MAX;
					a = rand48();
				end
				2: begin
					a = rand48() >> 4;
					l = a * 10 + $urandom_range(0, 2);
					if (l != 0)
						l--;
				end
				3: begin
					a = rand48() >> 7;
					l = a * 100 / 15 + $urandom_range(0, 2);
					if (l != 0)
						l--;
				end
				4: begin
					l = $urandom_range(1, 200);
					a = $urandom_range(0, 40);
				end
				default: begin
					l = rand48();
					a = (l / 100) * $urandom_range(0, 30) + $urandom_range(0, 99);
				end
			endcase
		end
		queue_req(KIND_STATUS, rand_pages(), BYTES_IN_W'(l), BYTES_IN_W'(a), c);
	endfunction

	function automatic int push_random(input bit ledger);
		int roll, n;
		logic [AMT_W-1:0] pg;
		roll = $urandom_range(0, 99);
		if (ledger) begin
			if (roll < 35)
				queue_req(KIND_RESERVE, rand_pages(), rand48(), rand48(), 1'($urandom));
			else if (roll < 55)
				queue_req(KIND_UNRESERVE, rand_pages(), rand48(), rand48(), 1'($urandom));
			else if (roll < 75)
				queue_req(KIND_CHARGE, rand_pages(), rand48(), rand48(), 1'($urandom));
			else if (roll < 85)
				queue_req(KIND_TICK, rand_pages(), rand48(), rand48(), 1'($urandom));
			else if (roll < 93)
				queue_req(KIND_STATUS, rand_pages(), '0, rand48(), 1'($urandom));
			else
				queue_req(KIND_W'($urandom_range(KIND_CHARGE + 1, 2 ** KIND_W - 1)),
					rand_pages(), rand48(), rand48(), 1'($urandom));
			return 1;
		end
		if (roll < 45) begin
			queue_status(1'b1);
			pg = rand_pages();
			queue_req(KIND_RESERVE, pg, rand48(), rand48(), 1'($urandom));
			n = 2;
			if ($urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 1) != 0)
					pg = pg + AMT_W'($urandom_range(0, 3)) - AMT_W'(1);
				else
					pg = rand_pages();
				queue_req(KIND_CHARGE, pg, rand48(), rand48(), 1'($urandom));
				n++;
			end
			return n;
		end
		if (roll < 60) begin
			n = $urandom_range(1, (stale_window < 16) ? int'(stale_window) + 3 : 12);
			for (int i = 0; i < n; i++)
				queue_req(KIND_TICK, rand_pages(), rand48(), rand48(), 1'($urandom));
			return n;
		end
		if (roll < 72)
			queue_status(1'b0);
		else if (roll < 82)
			queue_req(KIND_UNRESERVE, rand_pages(), rand48(), rand48(), 1'($urandom));
		else
			queue_req(KIND_W'($urandom_range(0, 2 ** KIND_W - 1)), rand_pages(), rand48(),
				rand48(), 1'($urandom));
		return 1;
	endfunction

	task automatic drain();
		@(posedge clk);
		while (request_backlog.size() != 0 || item_valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n, input bit ledger, input stall_mode_t sm,
			input int gmax);
		stall_mode = sm;
		gap_max = gmax;
		while (n > 0)
			n -= push_random(ledger);
		drain();
	endtask

	always @(posedge clk) begin : take_requests
		req_taken = arst_n && item_valid && !item_stall;
		if (req_taken)
			awaited_results.push_back(govern(kind, page_amount, mem_limit, headroom,
				crit_pressure));
	end

	always @(posedge clk) begin : take_config
		logic [PLIM_W-1:0] v;
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PAGE_LIMIT) begin
				v = cfg_data[PLIM_W-1:0];
				if (v != 0)
					cap_pages = (v > CAP_CEILING) ? PLIM_W'(CAP_CEILING) : v;
			end else if (cfg_index == CFG_STALE_WINDOW) begin
				stale_window = cfg_data[AGE_W-1:0];
			end
		end
	end

	always @(negedge clk) begin : drive_requests
		logic send;
		req_t nxt;
		if (arst_n && (!item_valid || req_taken)) begin
			send = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (request_backlog.size() != 0)
				send = 1'b1;
			if (send) begin
				nxt = request_backlog.pop_front();
				kind <= nxt.kind;
				page_amount <= nxt.pages;
				mem_limit <= nxt.lim;
				headroom <= nxt.avail;
				crit_pressure <= nxt.crit;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 :
						$urandom_range(1, gap_max);
				end
			end
			item_valid <= send;
		end
	end

	always @(negedge clk) begin : drive_stall
		logic hold;
		if (stall_mode == STALL_HOLD && hold_cnt < HOLD_CYCLES) begin
			hold = 1'b1;
			hold_cnt++;
		end else begin
			if (stall_mode != STALL_HOLD)
				hold_cnt = 0;
			case (stall_mode)
				STALL_NONE: hold = 1'b0;
				STALL_PATTERN: hold = (pat_cnt % 7) < 3;
				default: hold = ($urandom_range(0, 3) == 0);
			endcase
		end
		pat_cnt++;
		result_stall <= hold;
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				errors++;
				$error("result arrived with no request outstanding");
			end else begin
				want = awaited_results.pop_front();
				compare_field("granted", want.granted, granted);
				compare_field("refusal", want.refusal, refusal);
				compare_field("brake_on", want.brake_on, brake_on);
				compare_field("brake_changed", want.brake_changed, brake_changed);
				compare_field("footprint_on", want.footprint_on, footprint_on);
				compare_field("feed_stale", want.feed_stale, feed_stale);
				compare_field("pages_in_use", want.pages_in_use, pages_in_use);
				compare_field("credit_left", want.credit_left, credit_left);
				compare_field("negative_seen", want.negative_seen, negative_seen);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : main
		brake_st = 1'b0;
		footprint_st = 1'b0;
		clamp_st = 1'b0;
		feed_lim = '0;
		feed_age_st = '0;
		page_acct = 0;
		parked = '0;
		cap_pages = PLIM_W'(CAP_CEILING);
		stale_window = STALE_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ledger mode: cap, charge against credit, clamp of a negative count
		write_reg(CFG_PAGE_LIMIT, PLIM_W'(100));
		stall_mode = STALL_RANDOM;
		gap_max = 2;
		queue_req(KIND_RESERVE, '0, BYTES_MAX, BYTES_MAX, 1'b1);
		queue_req(KIND_RESERVE, AMT_W'(100), '0, '0, 1'b0);
		queue_req(KIND_RESERVE, AMT_W'(1), rand48(), rand48(), 1'b0);
		queue_req(KIND_CHARGE, AMT_W'(150), rand48(), rand48(), 1'b0);
		queue_req(KIND_CHARGE, AMT_W'(30), rand48(), rand48(), 1'b1);
		queue_req(KIND_UNRESERVE, AMT_MAX, rand48(), rand48(), 1'b0);
		for (int k = KIND_CHARGE + 1; k < 2 ** KIND_W; k++)
			queue_req(KIND_W'(k), rand_pages(), rand48(), rand48(), 1'($urandom));
		queue_req(KIND_TICK, '0, '0, '0, 1'b0);
		queue_req(KIND_STATUS, AMT_MAX, '0, BYTES_MAX, 1'b1);
		queue_req(KIND_RESERVE, AMT_W'(5), rand48(), rand48(), 1'b0);
		queue_req(KIND_UNRESERVE, AMT_W'(50), rand48(), rand48(), 1'b0);
		queue_req(KIND_RESERVE, AMT_W'(200), rand48(), rand48(), 1'b0);
		queue_req(KIND_CHARGE, AMT_MAX, rand48(), rand48(), 1'b0);
		drain();

		write_reg(CFG_PAGE_LIMIT, '0);
		random_phase(150, 1'b1, STALL_HOLD, 0);
		write_reg(CFG_PAGE_LIMIT, '1);
		random_phase(150, 1'b1, STALL_PATTERN, 5);
		write_reg(CFG_PAGE_LIMIT, PLIM_W'(1));
		random_phase(150, 1'b1, STALL_NONE, 0);

		// footprint mode: brake hysteresis, oversize, stale feed
		write_reg(CFG_PAGE_LIMIT, PLIM_W'(CAP_CEILING));
		write_reg(CFG_STALE_WINDOW, {3'b111, 16'd3});
		stall_mode = STALL_RANDOM;
		gap_max = 3;
		queue_req(KIND_STATUS, AMT_MAX, BYTES_MAX, BYTES_MAX, 1'b1);
		queue_req(KIND_RESERVE, AMT_MAX, rand48(), rand48(), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_IN_W'(1000), BYTES_IN_W'(50), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_IN_W'(1000), BYTES_IN_W'(140), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_IN_W'(1000), BYTES_IN_W'(150), 1'b0);
		queue_req(KIND_RESERVE, AMT_W'(1), rand48(), rand48(), 1'b0);
		queue_req(KIND_RESERVE, '0, rand48(), rand48(), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_IN_W'(100000), BYTES_IN_W'(9999), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_IN_W'(100000), BYTES_IN_W'(15000), 1'b0);
		repeat (4)
			queue_req(KIND_TICK, rand_pages(), rand48(), rand48(), 1'($urandom));
		queue_req(KIND_RESERVE, AMT_W'(1), rand48(), rand48(), 1'b0);
		queue_req(KIND_STATUS, '0, BYTES_MAX, '0, 1'b0);
		drain();

		// drive the count into both saturation limits, no clamp in this mode
		queue_req(KIND_STATUS, '0, BYTES_MAX, BYTES_MAX, 1'b0);
		repeat (40)
			queue_req(KIND_UNRESERVE, AMT_MAX - $urandom_range(0, 1000), rand48(), rand48(),
				1'b0);
		queue_req(KIND_RESERVE, AMT_W'(7), rand48(), rand48(), 1'b0);
		repeat (40)
			queue_req(KIND_CHARGE, AMT_MAX - $urandom_range(0, 1000), rand48(), rand48(),
				1'b0);
		queue_req(KIND_RESERVE, AMT_MAX, rand48(), rand48(), 1'b0);
		drain();

		write_reg(CFG_STALE_WINDOW, '0);
		random_phase(200, 1'b0, STALL_RANDOM, 4);
		write_reg(CFG_STALE_WINDOW, CFG_DATA_W'(5));
		random_phase(200, 1'b0, STALL_HOLD, 0);
		write_reg(CFG_STALE_WINDOW, {3'($urandom), 16'hffff});
		random_phase(200, 1'b0, STALL_PATTERN, 3);
		write_reg(CFG_PAGE_LIMIT, PLIM_W'(300));
		write_reg(CFG_STALE_WINDOW, CFG_DATA_W'(20));
		random_phase(200, 1'b0, STALL_RANDOM, 0);

		write_reg(CFG_STALE_WINDOW, CFG_DATA_W'(2000));
		random_phase(100, 1'b0, STALL_RANDOM, 6);

		repeat (8) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
